/* rtl/tbl_pkg.sv */
// Shared types and constants of the token bucket limiter.
// Depends on nothing; used by tbl_serial_div and token_bucket_limiter.
`default_nettype none

package tbl_pkg;

  localparam int TIME_WIDTH  = 32;
  localparam int TOKEN_WIDTH = 16;

  localparam int CFG_WIDTH    = (TIME_WIDTH > TOKEN_WIDTH) ? TIME_WIDTH : TOKEN_WIDTH;
  localparam int CFG_IDX_W    = 2;
  localparam int ACT_W        = 2;
  localparam int STATUS_W     = 2;
  localparam int IN_DATA_W    = ((TOKEN_WIDTH + TIME_WIDTH + 7) / 8) * 8;
  localparam int IN_USER_W    = ACT_W;
  localparam int OUT_DATA_W   = ((TOKEN_WIDTH + 7) / 8) * 8;
  localparam int OUT_USER_W   = STATUS_W + 1;
  localparam int DIV_CNT_W    = $clog2(TIME_WIDTH + 1);
  localparam int QEXT_W       = TIME_WIDTH + TOKEN_WIDTH;

  localparam logic [TOKEN_WIDTH-1:0] CAPACITY_RST        = TOKEN_WIDTH'(16);
  localparam logic [TIME_WIDTH-1:0]  REFILL_INTERVAL_RST = TIME_WIDTH'(1000);
  localparam logic [TOKEN_WIDTH-1:0] REFILL_AMOUNT_RST   = TOKEN_WIDTH'(1);

  typedef enum logic [ACT_W-1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_QUERY   = 2'd1,
    ACT_RESTART = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVER = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY        = 2'd0,
    CFG_REFILL_INTERVAL = 2'd1,
    CFG_REFILL_AMOUNT   = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

/* rtl/tbl_serial_div.sv */
// Restoring divider of TIME_WIDTH-bit operands, one quotient bit per cycle.
// Depends on tbl_pkg for the time width and the step counter width.
`default_nettype none

module tbl_serial_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [tbl_pkg::TIME_WIDTH-1:0] dividend_i,
  input  wire logic [tbl_pkg::TIME_WIDTH-1:0] divisor_i,
  output      logic                           done_o,
  output      logic [tbl_pkg::TIME_WIDTH-1:0] quot_o,
  output      logic [tbl_pkg::TIME_WIDTH-1:0] rem_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [tbl_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [tbl_pkg::TIME_WIDTH-1:0] rem_q, rem_d;
  logic [tbl_pkg::TIME_WIDTH-1:0] quot_q, quot_d;
  logic [tbl_pkg::TIME_WIDTH-1:0] dvs_q, dvs_d;
  logic [tbl_pkg::TIME_WIDTH:0]   rem_shift;
  logic                           fits;

  assign rem_shift = {rem_q, quot_q[tbl_pkg::TIME_WIDTH-1]};
  assign fits      = rem_shift >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = tbl_pkg::DIV_CNT_W'(tbl_pkg::TIME_WIDTH);
      rem_d  = '0;
      quot_d = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // Shift in the next dividend bit, subtract where the divisor fits
      rem_d  = fits ? tbl_pkg::TIME_WIDTH'(rem_shift - {1'b0, dvs_q})
                    : rem_shift[tbl_pkg::TIME_WIDTH-1:0];
      quot_d = {quot_q[tbl_pkg::TIME_WIDTH-2:0], fits};
      cnt_d  = cnt_q - tbl_pkg::DIV_CNT_W'(1);
      if (cnt_q == tbl_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* rtl/token_bucket_limiter.sv */
// Token bucket rate limiter: top level with sequencer, bucket state and output register.
// Depends on tbl_pkg and tbl_serial_div.
//
// Channel   Dir  Handshake                  Contents
// s_axis    in   tvalid/tready              tuser: action; tdata: count, now_ms
// m_axis    out  tvalid/tready              tuser: status, allowed; tdata: token_level
// cfg       in   cfg_we_i (no wait)         cfg_idx_i selects register, cfg_data_i value
//
// An item that refills passes from acceptance through decode, the serial divider of elapsed
// time by the refill interval (one quotient bit per cycle), refill and grant to its result
// standing in the output register; the refill step is skipped when less than a whole
// interval has passed. Items that skip the divider (zero count, oversize count, restart,
// unused action, zero interval) go from decode to grant or straight to the output step.
// Reset leaves the bucket empty with refill time zero and the registers at their defaults.
// A new item is taken while the previous result still waits; a stalled output holds
// the sequencer only at its final step.
`default_nettype none

module token_bucket_limiter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input items
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [tbl_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // count, now_ms
  input  wire logic [tbl_pkg::IN_USER_W-1:0]   s_axis_tuser,  // action
  // result items
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output      logic [tbl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // token_level
  output      logic [tbl_pkg::OUT_USER_W-1:0]  m_axis_tuser,  // status, allowed
  // configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [tbl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tbl_pkg::CFG_WIDTH-1:0]   cfg_data_i
);

  localparam int TW = tbl_pkg::TIME_WIDTH;
  localparam int KW = tbl_pkg::TOKEN_WIDTH;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_DIV    = 6'b000100,
    S_REFILL = 6'b001000,
    S_GRANT  = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e           state_q, state_d;

  // configuration registers
  logic [KW-1:0]    cap_q, cap_d;
  logic [TW-1:0]    interval_q, interval_d;
  logic [KW-1:0]    amount_q, amount_d;

  // bucket state
  logic [KW-1:0]    token_q, token_d;
  logic [TW-1:0]    last_q, last_d;

  // item in flight
  tbl_pkg::action_e act_q, act_d;
  logic [KW-1:0]    count_q, count_d;
  logic [TW-1:0]    now_q, now_d;
  tbl_pkg::status_e status_q, status_d;
  logic             allowed_q, allowed_d;
  logic [2*KW-1:0]  prod_q, prod_d;
  logic             sat_q, sat_d;

  // output register
  logic             out_valid_q, out_valid_d;
  tbl_pkg::status_e out_status_q, out_status_d;
  logic             out_allowed_q, out_allowed_d;
  logic [KW-1:0]    out_level_q, out_level_d;

  logic                        in_accept;
  logic                        out_free;
  logic                        div_start;
  logic                        div_done;
  logic [TW-1:0]               div_quot;
  logic [TW-1:0]               div_rem;
  logic [TW-1:0]               elapsed;
  logic [tbl_pkg::QEXT_W-1:0]  quot_ext;
  logic [KW-1:0]               missing;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign elapsed       = now_q - last_q;
  assign quot_ext      = tbl_pkg::QEXT_W'(div_quot);
  assign missing       = cap_q - token_q;

  tbl_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed),
    .divisor_i  (interval_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d       = state_q;
    cap_d         = cap_q;
    interval_d    = interval_q;
    amount_d      = amount_q;
    token_d       = token_q;
    last_d        = last_q;
    act_d         = act_q;
    count_d       = count_q;
    now_d         = now_q;
    status_d      = status_q;
    allowed_d     = allowed_q;
    prod_d        = prod_q;
    sat_d         = sat_q;
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_allowed_d = out_allowed_q;
    out_level_d   = out_level_q;
    div_start     = 1'b0;

    // clear the output once it has been taken
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (tbl_pkg::cfg_idx_e'(cfg_idx_i))
        tbl_pkg::CFG_CAPACITY:        cap_d      = cfg_data_i[KW-1:0];
        tbl_pkg::CFG_REFILL_INTERVAL: interval_d = cfg_data_i[TW-1:0];
        tbl_pkg::CFG_REFILL_AMOUNT:   amount_d   = cfg_data_i[KW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          act_d   = tbl_pkg::action_e'(s_axis_tuser[tbl_pkg::ACT_W-1:0]);
          count_d = s_axis_tdata[KW-1:0];
          now_d   = s_axis_tdata[KW+TW-1:KW];
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        status_d  = tbl_pkg::ST_OK;
        allowed_d = 1'b0;
        state_d   = S_DONE;
        case (act_q)
          tbl_pkg::ACT_ACQUIRE: begin
            if (count_q == '0) begin
              status_d = tbl_pkg::ST_ZERO;
            end else if (count_q > cap_q) begin
              status_d = tbl_pkg::ST_OVER;
            end else if (interval_q == '0) begin
              state_d = S_GRANT;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          tbl_pkg::ACT_QUERY: begin
            if (interval_q == '0) begin
              state_d = S_GRANT;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          tbl_pkg::ACT_RESTART: begin
            token_d = cap_q;
            last_d  = now_q;
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          if (div_quot == '0) begin
            // less than one whole interval: nothing to refill
            state_d = S_GRANT;
          end else begin
            prod_d  = {{KW{1'b0}}, quot_ext[KW-1:0]} * {{KW{1'b0}}, amount_q};
            sat_d   = |quot_ext[tbl_pkg::QEXT_W-1:KW];
            // advance by whole intervals only: now minus the remainder
            last_d  = now_q - div_rem;
            state_d = S_REFILL;
          end
        end
      end
      S_REFILL: begin
        // a zero refill amount adds nothing however long the wait
        if (token_q >= cap_q) begin
          token_d = cap_q;
        end else if ((amount_q != '0) &&
                     (sat_q || (prod_q >= {{KW{1'b0}}, missing}))) begin
          token_d = cap_q;
        end else begin
          token_d = token_q + prod_q[KW-1:0];
        end
        state_d = S_GRANT;
      end
      S_GRANT: begin
        if ((act_q == tbl_pkg::ACT_ACQUIRE) && (token_q >= count_q)) begin
          token_d   = token_q - count_q;
          allowed_d = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_status_d  = status_q;
          out_allowed_d = allowed_q;
          out_level_d   = token_q;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= tbl_pkg::CAPACITY_RST;
      interval_q  <= tbl_pkg::REFILL_INTERVAL_RST;
      amount_q    <= tbl_pkg::REFILL_AMOUNT_RST;
      token_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      interval_q  <= interval_d;
      amount_q    <= amount_d;
      token_q     <= token_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q         <= act_d;
    count_q       <= count_d;
    now_q         <= now_d;
    status_q      <= status_d;
    allowed_q     <= allowed_d;
    prod_q        <= prod_d;
    sat_q         <= sat_d;
    out_status_q  <= out_status_d;
    out_allowed_q <= out_allowed_d;
    out_level_q   <= out_level_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tbl_pkg::OUT_DATA_W'(out_level_q);
  assign m_axis_tuser  = {out_allowed_q, out_status_q};

  // the divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  // an accepted item always moves on to decode
  a_accept_to_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_DECODE))
    else $error("accepted item did not reach decode");

  // a granted acquire always reports status ok
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_allowed_q) |-> (out_status_q == tbl_pkg::ST_OK))
    else $error("grant reported with a nonzero status");

  // a result only appears from the final step
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result loaded outside the final step");

endmodule

`default_nettype wire
